// ===== sv/rgb_to_hsv_converter_top_macros.svh =====
// Assertion macros used by the RGB to HSV converter top level
`ifndef RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rhc check failed");

// next-cycle implication, disabled during reset
`define RHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rhc check failed");

`endif

// ===== sv/rhc_pkg.sv =====
// Constants and types shared by the RGB to HSV converter
`default_nettype none

package rhc_pkg;

    localparam int COLOR_BITS    = 8;
    localparam int HUE_FRAC_BITS = 6;

    localparam int PORT_W    = 8;
    localparam int HUE_W     = 15;
    localparam int DEG_ONE   = 1 << HUE_FRAC_BITS;
    localparam int HUE_LIMIT = 360 * DEG_ONE;
    localparam int CHAN_FULL = (1 << COLOR_BITS) - 1;
    localparam int HUE_Q_W   = $clog2(HUE_LIMIT);
    localparam int Q_W       = (HUE_Q_W > COLOR_BITS) ? HUE_Q_W : COLOR_BITS;
    localparam int NUM_W     = COLOR_BITS + Q_W;

    typedef logic [COLOR_BITS-1:0] t_chan;
    typedef logic [NUM_W-1:0]      t_num;

    typedef struct packed {
        t_chan          rem;
        logic [Q_W-1:0] nq;
        t_chan          div;
    } t_lane;

    typedef struct packed {
        t_lane hue;
        t_lane sat;
        t_chan value;
    } t_item;

endpackage

`default_nettype wire

// ===== sv/rhc_front.sv =====
// Input stage: max, min, delta and the numerators for the two divisions
`default_nettype none

module rhc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [7:0]           i_red,
    input  wire  [7:0]           i_green,
    input  wire  [7:0]           i_blue,
    output logic                 o_valid,
    input  wire                  i_ready,
    output rhc_pkg::t_item       o_item
);
    import rhc_pkg::*;

    localparam t_num K60  = NUM_W'(60 * DEG_ONE);
    localparam t_num K120 = NUM_W'(120 * DEG_ONE);
    localparam t_num K240 = NUM_W'(240 * DEG_ONE);
    localparam t_num K360 = NUM_W'(360 * DEG_ONE);
    localparam t_num KFULL = NUM_W'(CHAN_FULL);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    t_chan r, g, b, mx, mn, delta, diff;
    t_num  base, prod, hue_num, sat_num;
    logic  add;

    always_comb begin
        r = COLOR_BITS'(i_red);
        g = COLOR_BITS'(i_green);
        b = COLOR_BITS'(i_blue);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;

        priority if (mx == r) begin
            if (g >= b) begin
                base = '0;
                add  = 1'b1;
                diff = g - b;
            end else begin
                base = K360;
                add  = 1'b0;
                diff = b - g;
            end
        end else if (mx == g) begin
            base = K120;
            add  = (b >= r);
            diff = (b >= r) ? (b - r) : (r - b);
        end else begin
            base = K240;
            add  = (r >= g);
            diff = (r >= g) ? (r - g) : (g - r);
        end

        prod = K60 * NUM_W'(diff);
        if (delta == '0) begin
            hue_num = '0;
        end else if (add) begin
            hue_num = base * NUM_W'(delta) + prod;
        end else begin
            hue_num = base * NUM_W'(delta) - prod;
        end
        sat_num = KFULL * NUM_W'(delta);

        n_item.hue.rem = hue_num[NUM_W-1:Q_W];
        n_item.hue.nq  = hue_num[Q_W-1:0];
        n_item.hue.div = (delta == '0) ? COLOR_BITS'(1) : delta;
        n_item.sat.rem = sat_num[NUM_W-1:Q_W];
        n_item.sat.nq  = sat_num[Q_W-1:0];
        n_item.sat.div = (mx == '0) ? COLOR_BITS'(1) : mx;
        n_item.value   = mx;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rhc_div_cell.sv =====
// Division cell: one restoring quotient bit for hue and saturation
`default_nettype none

module rhc_div_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  rhc_pkg::t_item       i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output rhc_pkg::t_item       o_item
);
    import rhc_pkg::*;

    function automatic t_lane div_step(input t_lane a);
        logic [COLOR_BITS:0] t;
        logic [COLOR_BITS:0] d;
        t_lane               s;
        t = {a.rem, a.nq[Q_W-1]};
        d = {1'b0, a.div};
        s = a;
        if (t >= d) begin
            s.rem = COLOR_BITS'(t - d);
            s.nq  = {a.nq[Q_W-2:0], 1'b1};
        end else begin
            s.rem = t[COLOR_BITS-1:0];
            s.nq  = {a.nq[Q_W-2:0], 1'b0};
        end
        return s;
    endfunction

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.hue   = div_step(i_item.hue);
        n_item.sat   = div_step(i_item.sat);
        n_item.value = i_item.value;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rgb_to_hsv_converter_top.sv =====
// RGB to HSV converter: input stage followed by a chain of division cells
// Input channel: i_valid / o_ready with i_red, i_green, i_blue (8 bits each).
// Output channel: o_valid / i_ready with o_hue (1/64 degree units, 15 bits),
// o_saturation (255 = full) and o_brightness (largest channel).
// One result item leaves for every accepted input item, in order.
// The input stage registers max, min and the numerators, then 15 division
// cells follow, each producing one quotient bit of hue and saturation.
// Throughput is one item per clock while i_ready stays high; every stage is a
// register with its own valid bit, and each stage takes a new item while its
// own result is still held, so the last cell acts as the output register.
// When i_ready stays low, items pile up in the chain, bubbles collapse,
// and o_ready falls only once all 16 stages are full.
// Synchronous active-low reset empties every stage; the item registers are not reset.
`default_nettype none

`include "rgb_to_hsv_converter_top_macros.svh"

module rgb_to_hsv_converter_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_red,
    input  wire  [7:0]  i_green,
    input  wire  [7:0]  i_blue,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [14:0] o_hue,
    output logic [7:0]  o_saturation,
    output logic [7:0]  o_brightness
);
    import rhc_pkg::*;

    logic  w_valid [0:Q_W];
    logic  w_ready [0:Q_W];
    t_item w_item  [0:Q_W];

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_item  (w_item[0])
    );

    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    assign w_ready[Q_W]  = i_ready;
    assign o_valid       = w_valid[Q_W];
    assign o_hue         = HUE_W'(w_item[Q_W].hue.nq);
    assign o_saturation  = PORT_W'(w_item[Q_W].sat.nq);
    assign o_brightness  = PORT_W'(w_item[Q_W].value);

    `RHC_ASSERT_IMP(a_hue_range, i_clk, i_rst_n, o_valid, o_hue < HUE_LIMIT)
    `RHC_ASSERT_IMP(a_grey_hue, i_clk, i_rst_n, o_valid && o_saturation == 8'd0, o_hue == 15'd0)
    `RHC_ASSERT_IMP(a_black_sat, i_clk, i_rst_n, o_valid && o_brightness == 8'd0, o_saturation == 8'd0)
    `RHC_ASSERT_NXT(a_front_load, i_clk, i_rst_n, i_valid && o_ready, w_valid[0])

endmodule

`default_nettype wire

// ===== tb/sv/rgb_to_hsv_converter_top_tb.sv =====
// Testbench for the RGB to HSV converter: directed and random pixels against an HSV predictor
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  sat;
        logic [7:0]  value;
    } t_hsv;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_red = 8'd0;
    logic [7:0]  i_green = 8'd0;
    logic [7:0]  i_blue = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [14:0] o_hue;
    logic [7:0]  o_saturation;
    logic [7:0]  o_brightness;

    t_hsv hsv_expected[$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   pixels_sent = 0;
    int   results_checked = 0;
    int   mismatches = 0;

    rgb_to_hsv_converter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_hsv predict_hsv(input logic [7:0] r8, input logic [7:0] g8,
                                         input logic [7:0] b8);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   delta;
        int   num;
        t_hsv res;
        r = int'(r8);
        g = int'(g8);
        b = int'(b8);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res.hue = '0;
        res.sat = '0;
        res.value = 8'(mx);
        if (delta != 0) begin
            if (mx == r) begin
                num = 60 * rhc_pkg::DEG_ONE * (g - b);
                if (g < b) num += 360 * rhc_pkg::DEG_ONE * delta;
            end else if (mx == g) begin
                num = 120 * rhc_pkg::DEG_ONE * delta + 60 * rhc_pkg::DEG_ONE * (b - r);
            end else begin
                num = 240 * rhc_pkg::DEG_ONE * delta + 60 * rhc_pkg::DEG_ONE * (r - g);
            end
            res.hue = 15'(num / delta);
        end
        if (mx != 0) res.sat = 8'((rhc_pkg::CHAN_FULL * delta) / mx);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            hsv_expected.push_back(predict_hsv(i_red, i_green, i_blue));
    end

    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_valid && i_ready) begin
            if (hsv_expected.size() == 0) begin
                $display("%0t: unexpected item hue %0d sat %0d value %0d", $time,
                         o_hue, o_saturation, o_brightness);
                mismatches++;
            end else begin
                want = hsv_expected.pop_front();
                results_checked++;
                if (o_hue !== want.hue) begin
                    $display("%0t: hue expected %0d actual %0d", $time, want.hue, o_hue);
                    mismatches++;
                end
                if (o_saturation !== want.sat) begin
                    $display("%0t: saturation expected %0d actual %0d", $time, want.sat,
                             o_saturation);
                    mismatches++;
                end
                if (o_brightness !== want.value) begin
                    $display("%0t: brightness expected %0d actual %0d", $time, want.value,
                             o_brightness);
                    mismatches++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_red   <= 8'($urandom);
            i_green <= 8'($urandom);
            i_blue  <= 8'($urandom);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_random_pixels(input int count);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] base;
        for (int n = 0; n < count; n++) begin
            c0 = 8'($urandom);
            c1 = 8'($urandom);
            c2 = 8'($urandom);
            case ($urandom_range(9))
                0: begin
                    c1 = c0;
                    c2 = c0;
                end
                1: begin
                    base = 8'($urandom_range(1, 255));
                    c0 = base;
                    c1 = base;
                    c2 = 8'($urandom_range(0, base));
                end
                2: begin
                    base = 8'($urandom_range(0, 250));
                    c0 = base + 8'($urandom_range(0, 5));
                    c1 = base + 8'($urandom_range(0, 5));
                    c2 = base + 8'($urandom_range(0, 5));
                end
                default: ;
            endcase
            case ($urandom_range(2))
                0: send_pixel(c0, c1, c2);
                1: send_pixel(c2, c0, c1);
                default: send_pixel(c1, c2, c0);
            endcase
        end
    endtask

    task automatic test_corner_pixels();
        logic [23:0] corners[] = '{
            24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010101,
            24'hFF0001, 24'hFF0100, 24'hC80AC8, 24'h010000, 24'h000100,
            24'h000001, 24'hAA55AA, 24'h55AA55, 24'hFFFE00, 24'h00FFFE,
            24'hFE00FF, 24'h0100FF, 24'hFFFFFE, 24'h0A141E
        };
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (corners[k])
            send_pixel(corners[k][23:16], corners[k][15:8], corners[k][7:0]);
    endtask

    task automatic test_random_slow_sink();
        send_idle_pct = 21;
        recv_idle_pct = 69;
        send_random_pixels(530);
    endtask

    task automatic test_random_slow_source();
        send_idle_pct = 69;
        recv_idle_pct = 21;
        send_random_pixels(530);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_pixels(540);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_pixels();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();
        i_valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Converted %0d pixels (corners, greys, tied maxima, near-grey and random)",
                 pixels_sent);
        $display("under slow-sink, slow-source and full-rate flow; %0d results compared",
                 results_checked);
        if (mismatches == 0 && hsv_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Timeout with %0d items outstanding", hsv_expected.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
